>>> sv/ffd_pkg.sv
package ffd_pkg;

	// request opcodes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// frame status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_HDR_ERR   = 2'd1;
	localparam logic [1:0] ST_TERM_ERR  = 2'd2;
	localparam logic [1:0] ST_TIMEOUT   = 2'd3;

	// reply kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// register indexes
	localparam logic [1:0] REG_HEADER  = 2'd0;
	localparam logic [1:0] REG_TERM    = 2'd1;
	localparam logic [1:0] REG_LEN     = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	localparam logic [1:0]  LAST_WORD_POS = 2'd3;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

endpackage

>>> sv/fixed_frame_deframer.sv
// Channel  | Direction | Signals                          | Contents
// ---------+-----------+----------------------------------+-----------------------------------
// s_*      | in        | s_tvalid s_tready s_tdata s_tuser | opcode, received byte, read index
// m_*      | out       | m_tvalid m_tready m_tdata m_tuser | reply kind, frame status, read data
// p*       | in/out    | psel penable pwrite paddr ...    | four 32-bit registers at 0x0..0xC
//
// One request is taken every cycle while s_tready is high; replies pass s1, then s2.
// The rate is set by the single payload memory: one write or one read per request.
// Reset clears the frame state, one valid bit per memory entry and the registers, but sets
// the timeout to 1000; an entry never written reads as zero, so there is no clearing pass.
// Two result slots (memory read stage and output register) absorb a stalled m_tready;
// s_tready drops only while both are full.
module fixed_frame_deframer
	import ffd_pkg::*;
#(
	parameter int PAYLOAD_MAX = 56
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [13:8] read_index, [15:14] zero
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] frame_status, [9:2] read_data, [15:10] zero
	output logic        m_tuser,   // [0] reply_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH  = 2 * PAYLOAD_MAX;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] BANK_OFS = ADDR_W'(PAYLOAD_MAX);

	typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PAYLOAD, PH_TERM} phase_t;

	// configuration registers
	logic [31:0] hdr_q;
	logic [31:0] term_q;
	logic [5:0]  len_q;
	logic [31:0] tmo_q;

	// frame state
	phase_t      phase_q;
	logic [1:0]  pos_q;
	logic [5:0]  cnt_q;
	logic [31:0] el_q;
	logic        cbank_q;

	// payload memory and its valid bits
	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	// result pipeline
	logic       valid_s1;
	logic       kind_s1;
	logic [1:0] status_s1;
	logic       rd_ok_s1;
	logic [7:0] rd_data_s1;
	logic       valid_s2;
	logic       kind_s2;
	logic [1:0] status_s2;
	logic [7:0] data_s2;

	logic       accept;
	logic       adv_s1;
	logic       cfg_wr;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic [5:0] read_index;
	logic [5:0] eff_len;

	phase_t      cur_phase;
	phase_t      phase_n;
	logic [1:0]  pos_n;
	logic [5:0]  cnt_n;
	logic [31:0] el_n;
	logic [31:0] el_inc;
	logic [6:0]  cnt_inc;
	logic        cbank_n;
	logic        res_n;
	logic        res_kind_n;
	logic [1:0]  res_status_n;
	logic        wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic        rd_en;
	logic        in_range;

	assign opcode     = s_tuser;
	assign data_byte  = s_tdata[7:0];
	assign read_index = s_tdata[13:8];

	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	assign eff_len = (int'(len_q) > PAYLOAD_MAX) ? 6'(PAYLOAD_MAX) : len_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= '0;
			term_q <= '0;
			len_q  <= '0;
			tmo_q  <= TIMEOUT_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_HEADER:  hdr_q  <= pwdata;
				REG_TERM:    term_q <= pwdata;
				REG_LEN:     len_q  <= pwdata[5:0];
				REG_TIMEOUT: tmo_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HEADER:  prdata = hdr_q;
			REG_TERM:    prdata = term_q;
			REG_LEN:     prdata = {26'd0, len_q};
			REG_TIMEOUT: prdata = tmo_q;
			default:     prdata = '0;
		endcase
	end

	// ---------------- frame logic ----------------
	assign cur_phase = (phase_q == PH_IDLE) ? ((hdr_q != '0) ? PH_HEADER : PH_PAYLOAD) : phase_q;
	assign cnt_inc   = {1'b0, cnt_q} + 7'd1;
	assign el_inc    = (el_q == '1) ? el_q : el_q + 32'd1;
	assign wr_addr   = ADDR_W'(cnt_q) + (cbank_q ? '0 : BANK_OFS);
	assign rd_addr   = ADDR_W'(read_index) + (cbank_q ? BANK_OFS : '0);
	assign in_range  = read_index < eff_len;

	always_comb begin
		phase_n      = phase_q;
		pos_n        = pos_q;
		cnt_n        = cnt_q;
		el_n         = el_q;
		cbank_n      = cbank_q;
		res_n        = 1'b0;
		res_kind_n   = KIND_STATUS;
		res_status_n = ST_OK;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		case (opcode)
			OP_BYTE: begin
				if (eff_len == '0) begin
					// reception off: drop byte and abandon any open frame
					phase_n = PH_IDLE;
					pos_n   = '0;
					cnt_n   = '0;
					el_n    = '0;
				end else begin
					phase_n = cur_phase;
					case (cur_phase)
						PH_HEADER: begin
							if (data_byte != hdr_q[{pos_q, 3'b000} +: 8]) begin
								res_n        = 1'b1;
								res_status_n = ST_HDR_ERR;
							end else if (pos_q == LAST_WORD_POS) begin
								pos_n   = '0;
								cnt_n   = '0;
								phase_n = PH_PAYLOAD;
							end else begin
								pos_n = pos_q + 2'd1;
							end
						end
						PH_PAYLOAD: begin
							wr_en = int'(cnt_q) < PAYLOAD_MAX;
							cnt_n = cnt_inc[5:0];
							if (cnt_inc >= {1'b0, eff_len}) begin
								if (term_q == '0) begin
									cbank_n = !cbank_q;
									res_n   = 1'b1;
								end else begin
									pos_n   = '0;
									phase_n = PH_TERM;
								end
							end
						end
						PH_TERM: begin
							if (data_byte != term_q[{pos_q, 3'b000} +: 8]) begin
								res_n        = 1'b1;
								res_status_n = ST_TERM_ERR;
							end else if (pos_q == LAST_WORD_POS) begin
								cbank_n = !cbank_q;
								res_n   = 1'b1;
							end else begin
								pos_n = pos_q + 2'd1;
							end
						end
						default: ;
					endcase
				end
			end
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					el_n = el_inc;
					if (el_inc > tmo_q) begin
						res_n        = 1'b1;
						res_status_n = ST_TIMEOUT;
					end
				end
			end
			OP_READ: begin
				rd_en      = 1'b1;
				res_n      = 1'b1;
				res_kind_n = KIND_READ;
			end
			default: ;
		endcase
		// any frame status ends the frame
		if (res_n && res_kind_n == KIND_STATUS) begin
			phase_n = PH_IDLE;
			pos_n   = '0;
			cnt_n   = '0;
			el_n    = '0;
		end
	end

	// ---------------- payload memory ----------------
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem[wr_addr] <= data_byte;
		end
		if (accept && rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (accept && wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// ---------------- state and result pipeline ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			cnt_q     <= '0;
			el_q      <= '0;
			cbank_q   <= 1'b0;
			valid_s1  <= 1'b0;
			kind_s1   <= KIND_STATUS;
			status_s1 <= ST_OK;
			rd_ok_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			kind_s2   <= KIND_STATUS;
			status_s2 <= ST_OK;
			data_s2   <= '0;
		end else begin
			if (adv_s1) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					kind_s2   <= kind_s1;
					status_s2 <= status_s1;
					data_s2   <= rd_ok_s1 ? rd_data_s1 : '0;
				end
			end
			if (accept) begin
				phase_q   <= phase_n;
				pos_q     <= pos_n;
				cnt_q     <= cnt_n;
				el_q      <= el_n;
				cbank_q   <= cbank_n;
				valid_s1  <= res_n;
				kind_s1   <= res_kind_n;
				status_s1 <= res_status_n;
				rd_ok_s1  <= rd_en && in_range && vld_q[rd_addr];
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {6'd0, data_s2, status_s2};

endmodule

>>> sv/ffd_checker.sv
module ffd_checker
	import ffd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// hold a stalled reply
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled reply changed");

	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_READ |-> m_tdata[1:0] == ST_OK)
		else $error("readout reply carries a status");

	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STATUS |-> m_tdata[9:2] == 8'd0)
		else $error("status result carries data");

	// back-pressure only when the output itself is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("request refused without a stalled reply");

endmodule

bind fixed_frame_deframer ffd_checker u_ffd_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ffd_pkg::*;

	localparam int PAYLOAD_MAX     = 56;
	localparam int RANDOM_REQUESTS = 1800;
	localparam int PHASE_REQUESTS  = 150;
	localparam int STALL_LIMIT     = 1000;
	localparam int MAX_SHOWN       = 10;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef enum logic [1:0] {FR_IDLE, FR_HEADER, FR_PAYLOAD, FR_TERM} frame_phase_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] status;
		logic [7:0] data;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] data_byte, [13:8] read_index, [15:14] zero
	logic [1:0]  s_tuser;   // [1:0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [1:0] frame_status, [9:2] read_data, [15:10] zero
	logic        m_tuser;   // [0] reply_kind
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// register copies and frame tracking state
	logic [31:0]  header_cfg;
	logic [31:0]  term_cfg;
	logic [5:0]   len_cfg;
	logic [31:0]  timeout_cfg;
	frame_phase_t rx_phase;
	logic [1:0]   word_pos;
	int unsigned  bytes_taken;
	logic [31:0]  open_ticks;
	logic [7:0]   payload_mem [2][PAYLOAD_MAX];
	logic         live_bank;

	reply_t      pending_replies[$];
	reply_t      head;
	int unsigned mismatches = 0;
	int unsigned sent_requests = 0;
	int unsigned idle_cycles = 0;
	bit          quiet_tx;
	bit          quiet_rx;

	fixed_frame_deframer #(
		.PAYLOAD_MAX(PAYLOAD_MAX)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned frame_len();
		return (len_cfg > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(len_cfg);
	endfunction

	function automatic void reset_model();
		header_cfg  = '0;
		term_cfg    = '0;
		len_cfg     = '0;
		timeout_cfg = TIMEOUT_RESET;
		rx_phase    = FR_IDLE;
		word_pos    = '0;
		bytes_taken = 0;
		open_ticks  = '0;
		live_bank   = 1'b0;
		foreach (payload_mem[i, j])
			payload_mem[i][j] = '0;
	endfunction

	function automatic void end_frame(input logic [1:0] status);
		rx_phase    = FR_IDLE;
		word_pos    = '0;
		bytes_taken = 0;
		open_ticks  = '0;
		pending_replies.push_back('{KIND_STATUS, status, 8'd0});
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		int unsigned n;
		n = frame_len();
		if (n == 0) begin
			// reception off: drop the byte and any open frame
			rx_phase    = FR_IDLE;
			word_pos    = '0;
			bytes_taken = 0;
			open_ticks  = '0;
			return;
		end
		if (rx_phase == FR_IDLE) begin
			open_ticks  = '0;
			word_pos    = '0;
			bytes_taken = 0;
			rx_phase    = (header_cfg != 0) ? FR_HEADER : FR_PAYLOAD;
		end
		if (rx_phase == FR_HEADER) begin
			if (b != header_cfg[8*word_pos +: 8])
				end_frame(ST_HDR_ERR);
			else if (word_pos == LAST_WORD_POS) begin
				word_pos    = '0;
				bytes_taken = 0;
				rx_phase    = FR_PAYLOAD;
			end else
				word_pos++;
		end else if (rx_phase == FR_PAYLOAD) begin
			if (bytes_taken < PAYLOAD_MAX)
				payload_mem[!live_bank][bytes_taken] = b;
			bytes_taken++;
			if (bytes_taken >= n) begin
				if (term_cfg == 0) begin
					live_bank = !live_bank;
					end_frame(ST_OK);
				end else begin
					word_pos = '0;
					rx_phase = FR_TERM;
				end
			end
		end else begin
			if (b != term_cfg[8*word_pos +: 8])
				end_frame(ST_TERM_ERR);
			else if (word_pos == LAST_WORD_POS) begin
				live_bank = !live_bank;
				end_frame(ST_OK);
			end else
				word_pos++;
		end
	endfunction

	function automatic void take_tick();
		if (rx_phase == FR_IDLE)
			return;
		if (open_ticks != '1)
			open_ticks++;
		if (open_ticks > timeout_cfg)
			end_frame(ST_TIMEOUT);
	endfunction

	function automatic void take_read(input logic [5:0] idx);
		logic [7:0] v;
		v = (idx < frame_len()) ? payload_mem[live_bank][idx] : 8'd0;
		pending_replies.push_back('{KIND_READ, ST_OK, v});
	endfunction

	function automatic void predict_request(input logic [1:0] op, input logic [7:0] b,
			input logic [5:0] idx);
		sent_requests++;
		case (op)
			OP_BYTE: take_byte(b);
			OP_TICK: take_tick();
			OP_READ: take_read(idx);
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
	endfunction

	function automatic logic [5:0] pick_index();
		int unsigned lim;
		lim = frame_len();
		if (lim > 55)
			lim = 55;
		return $urandom_range(0, 1) ? 6'($urandom_range(0, lim)) : 6'($urandom_range(0, 55));
	endfunction

	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// reply checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_replies.size() == 0)
				note_mismatch("unexpected reply", 32'd0, {15'd0, m_tuser, m_tdata});
			else begin
				head = pending_replies.pop_front();
				if (m_tuser !== head.kind)
					note_mismatch("reply kind", 32'(head.kind), 32'(m_tuser));
				if (m_tdata[1:0] !== head.status)
					note_mismatch("frame status", 32'(head.status), 32'(m_tdata[1:0]));
				if (m_tdata[9:2] !== head.data)
					note_mismatch("read data", 32'(head.data), 32'(m_tdata[9:2]));
				if (m_tdata[15:10] !== 6'd0)
					note_mismatch("reply padding", 32'd0, 32'(m_tdata[15:10]));
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// reply side: hold off a random number of cycles before each reply
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			stall = quiet_rx ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1 || !m_tready);
			@(negedge clk);
		end
	end

	task automatic push_request(input logic [1:0] op, input logic [7:0] b,
			input logic [5:0] idx);
		int unsigned gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, idx, b};
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_request(op, b, idx);
	endtask

	task automatic send_byte(input logic [7:0] b);
		push_request(OP_BYTE, b, 6'($urandom_range(0, 55)));
	endtask

	task automatic send_tick();
		push_request(OP_TICK, 8'($urandom), 6'($urandom_range(0, 55)));
	endtask

	task automatic send_read(input logic [5:0] idx);
		push_request(OP_READ, 8'($urandom), idx);
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			send_byte(w[8*i +: 8]);
	endtask

	// wait until every reply is in and the pipeline has emptied
	task automatic drain_replies();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		drain_replies();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_HEADER: header_cfg = value;
			REG_TERM:   term_cfg = value;
			REG_LEN:    len_cfg = value[5:0];
			default:    timeout_cfg = value;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_regs();
		logic [1:0]  idx;
		logic [31:0] want;
		logic [31:0] mask;
		for (int r = 0; r < 4; r++) begin
			idx  = r[1:0];
			mask = '1;
			case (idx)
				REG_HEADER: want = header_cfg;
				REG_TERM:   want = term_cfg;
				REG_LEN: begin
					want = {26'd0, len_cfg};
					mask = 32'h3F;
				end
				default:    want = timeout_cfg;
			endcase
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= {idx, 2'b00};
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (pready !== 1'b1);
			if ((prdata & mask) !== want)
				note_mismatch("register readback", want, prdata & mask);
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic set_config(input logic [31:0] hdr, input logic [31:0] term,
			input logic [5:0] len, input logic [31:0] tmo);
		write_reg(REG_HEADER, hdr);
		write_reg(REG_TERM, term);
		write_reg(REG_LEN, {26'd0, len});
		write_reg(REG_TIMEOUT, tmo);
		check_regs();
	endtask

	task automatic test_reset_state();
		check_regs();
		send_read(6'd0);
		send_byte(8'hA5);   // reception off after reset
		send_tick();
		push_request(OP_NONE, 8'hFF, 6'd55);
	endtask

	task automatic test_header_terminator();
		set_config(32'hC35A_A53C, 32'h0080_FF01, 6'd1, TIMEOUT_RESET);
		send_word(header_cfg);
		send_byte(8'h9E);
		send_word(term_cfg);
		send_read(6'd0);
		send_byte(8'h00);   // header mismatch on the first byte
		send_word(header_cfg);
		send_byte(8'h47);
		send_byte(8'h02);   // terminator mismatch, bank stays
		send_read(6'd0);
	endtask

	task automatic test_timeout();
		set_config('0, '0, 6'd2, '0);
		send_byte(8'h5A);
		send_tick();
		send_tick();        // idle again: ignored
	endtask

	task automatic test_config_midframe();
		set_config('0, '0, 6'd4, TIMEOUT_RESET);
		send_byte(8'h11);
		send_byte(8'h22);
		write_reg(REG_LEN, 32'd1);   // below bytes taken: next byte closes the payload
		send_byte(8'h33);
		send_read(6'd0);
		write_reg(REG_LEN, 32'd3);
		send_byte(8'h44);
		write_reg(REG_LEN, 32'd0);   // abandon the open frame
		send_byte(8'h55);
		write_reg(REG_LEN, 32'd2);
		send_byte(8'h66);
		send_byte(8'h77);
		send_read(6'd1);
	endtask

	task automatic send_random_frame();
		logic [7:0]  stream[$];
		int unsigned n;
		n = frame_len();
		if (n == 0)
			n = $urandom_range(1, 4);
		if (header_cfg != 0)
			for (int i = 0; i < 4; i++)
				stream.push_back(header_cfg[8*i +: 8]);
		repeat (n) stream.push_back(8'($urandom));
		if (term_cfg != 0)
			for (int i = 0; i < 4; i++)
				stream.push_back(term_cfg[8*i +: 8]);
		// break some frames: corrupt one byte or cut the frame short
		case ($urandom_range(0, 7))
			0: stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom);
			1: void'(stream.pop_back());
			default: ;
		endcase
		foreach (stream[i]) begin
			case ($urandom_range(0, 15))
				0, 1: send_tick();
				2, 3: send_read(pick_index());
				4: push_request(OP_NONE, 8'($urandom), 6'($urandom_range(0, 55)));
				default: ;
			endcase
			send_byte(stream[i]);
		end
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 1))
				send_read(pick_index());
			else
				send_tick();
		end
	endtask

	task automatic test_random_traffic();
		int unsigned start_count;
		int unsigned phase_start;
		int unsigned phase;
		logic [5:0]  len;
		logic [31:0] tmo;
		start_count = sent_requests;
		phase = 0;
		while (sent_requests - start_count < RANDOM_REQUESTS) begin
			quiet_tx = (phase % 3 == 2);
			quiet_rx = (phase % 4 == 1);
			case (phase)
				0: set_config('0, '0, 6'd63, '1);
				1: set_config('1, '1, 6'd1, '0);
				2: set_config($urandom, '0, 6'd56, 32'd400);
				default: begin
					case ($urandom_range(0, 9))
						0: len = 6'd0;
						1: len = 6'($urandom_range(57, 63));
						2: len = 6'd56;
						default: len = 6'($urandom_range(1, 8));
					endcase
					case ($urandom_range(0, 9))
						0: tmo = '0;
						1: tmo = '1;
						2: tmo = $urandom_range(1, 4);
						default: tmo = $urandom_range(10, 60);
					endcase
					set_config(any_word(), any_word(), len, tmo);
				end
			endcase
			phase_start = sent_requests;
			while (sent_requests - phase_start < PHASE_REQUESTS)
				send_random_frame();
			phase++;
		end
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		reset_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_header_terminator();
		test_timeout();
		test_config_midframe();
		test_random_traffic();

		drain_replies();
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
sv/ffd_pkg.sv
sv/fixed_frame_deframer.sv
sv/ffd_checker.sv
dv/testbench.sv
